### sv/tksq_pkg.sv
// ----------------------------------------------------------------------------
// tksq_pkg: shared types and constants of the two-key sorted priority queue
// Entry layout, status codes, sequencer states and name byte masks.
// ----------------------------------------------------------------------------
package tksq_pkg;

	localparam int QueueDepthDefault = 16;
	localparam int NameBytes         = 20;

	typedef enum logic [1:0] {
		STAT_DONE  = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_INS_PRIME,
		S_INS_SHIFT,
		S_INS_PLACE,
		S_REM_PRIME,
		S_REM_SHIFT,
		S_FINISH
	} state_t;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_REMOVE = 1'b1
	} op_t;

	typedef struct packed {
		logic signed [15:0] primary_key;
		logic signed [15:0] secondary_key;
		logic [63:0]        name_low;
		logic [63:0]        name_mid;
		logic [31:0]        name_high;
	} entry_t;

	localparam int EntryW = $bits(entry_t);

	// Keeps the bytes of a word whose position in the name lies below NameBytes.
	function automatic logic [63:0] name_mask(int first, int nbytes);
		logic [63:0] m;
		m = '0;
		for (int b = 0; b < 8; b++) begin
			if (b < nbytes && first + b < NameBytes) begin
				m[b*8 +: 8] = 8'hFF;
			end
		end
		return m;
	endfunction

	localparam logic [63:0] LowMask  = name_mask(0, 8);
	localparam logic [63:0] MidMask  = name_mask(8, 8);
	localparam logic [63:0] HighMask = name_mask(16, 4);

endpackage

### sv/tksq_ram.sv
// ----------------------------------------------------------------------------
// tksq_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tksq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

### sv/tksq_cmp.sv
// ----------------------------------------------------------------------------
// tksq_cmp: two-key ordering compare
// Flags a stored entry that orders strictly ahead of the entry being inserted.
// ----------------------------------------------------------------------------
module tksq_cmp (
	input  tksq_pkg::entry_t stored,
	input  tksq_pkg::entry_t incoming,
	output logic             stored_first
);

	import tksq_pkg::*;

	logic prim_lt;
	logic prim_eq;
	logic sec_lt;

	assign prim_lt = stored.primary_key < incoming.primary_key;
	assign prim_eq = stored.primary_key == incoming.primary_key;
	assign sec_lt  = stored.secondary_key < incoming.secondary_key;

	// Equal keys do not count, so a new entry lands ahead of its equals.
	assign stored_first = prim_lt || (prim_eq && sec_lt);

endmodule

### sv/two_key_sorted_priority_queue_top.sv
// ----------------------------------------------------------------------------
// two_key_sorted_priority_queue_top: bounded sorted min-priority queue
// Entries are kept in a RAM in ascending two-key order, front at address 0.
// ----------------------------------------------------------------------------
// Usage: an input word is accepted when in_valid and in_ready are both high.
// operation 0 inserts the entry (keys and name), operation 1 removes the front
// entry. Each input word yields exactly one output word on the out_valid /
// out_ready channel with status, occupancy and, for a remove, the entry.
// One shared compare unit and one RAM read and write port per cycle do the
// work: an insert walks from the back of the queue, moving one entry up per
// cycle until the compare unit finds its slot, and a remove moves every
// entry down by one, one per cycle; an insert to a full queue or a remove
// from an empty one goes straight to its result. in_ready is high only
// between items, so the next word can be accepted in the cycle after the
// result is issued. The result waits in an output register, so a new word
// is accepted while it is pending; if the receiver stalls, the next item
// holds in its last step until the output register frees. Reset empties
// the queue at once; RAM contents are not cleared, since only occupied
// entries are ever used.
// ----------------------------------------------------------------------------
module two_key_sorted_priority_queue_top #(
	parameter int QUEUE_DEPTH = tksq_pkg::QueueDepthDefault
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic                                 operation,
	input  logic signed [15:0]                   primary_key,
	input  logic signed [15:0]                   secondary_key,
	input  logic [63:0]                          name_bytes_low,
	input  logic [63:0]                          name_bytes_mid,
	input  logic [31:0]                          name_bytes_high,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [1:0]                           status,
	output logic [$clog2(QUEUE_DEPTH+1)-1:0]     occupancy,
	output logic signed [15:0]                   out_primary_key,
	output logic signed [15:0]                   out_secondary_key,
	output logic [63:0]                          out_name_low,
	output logic [63:0]                          out_name_mid,
	output logic [31:0]                          out_name_high
);

	import tksq_pkg::*;

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [CW-1:0] DepthCnt = CW'(QUEUE_DEPTH);

	state_t          state_q, state_d;
	logic [CW-1:0]   count_q;
	logic [AW-1:0]   idx_q;
	entry_t          new_q;
	entry_t          front_q;
	op_t             op_q;
	status_t         status_q;

	logic            out_valid_q;
	status_t         out_status_q;
	logic [CW-1:0]   out_count_q;
	entry_t          out_entry_q;

	logic            ram_we;
	logic [AW-1:0]   ram_waddr;
	entry_t          ram_wdata;
	logic [AW-1:0]   ram_raddr;
	logic [EntryW-1:0] ram_rdata;
	entry_t          rd_entry;
	logic            stored_first;
	logic            out_free;
	logic            accept;
	logic            rem_last;

	assign rd_entry = entry_t'(ram_rdata);
	assign out_free = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;
	assign rem_last = {{(CW-AW){1'b0}}, idx_q} == count_q - CW'(1);

	tksq_ram #(
		.WIDTH(EntryW),
		.DEPTH(QUEUE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(EntryW'(ram_wdata)),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	tksq_cmp u_cmp (
		.stored      (rd_entry),
		.incoming    (new_q),
		.stored_first(stored_first)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = idx_q + AW'(1);
		ram_wdata = rd_entry;
		ram_raddr = idx_q;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (operation == OP_INSERT) begin
						if (count_q == DepthCnt) begin
							state_d = S_FINISH;
						end else if (count_q == '0) begin
							state_d = S_INS_PLACE;
						end else begin
							state_d = S_INS_PRIME;
						end
					end else begin
						if (count_q == '0) begin
							state_d = S_FINISH;
						end else begin
							state_d = S_REM_PRIME;
						end
					end
				end
			end
			S_INS_PRIME: begin
				state_d = S_INS_SHIFT;
			end
			S_INS_SHIFT: begin
				// Read one entry lower while this one is compared and moved.
				ram_we    = 1'b1;
				ram_raddr = idx_q - AW'(1);
				if (stored_first) begin
					ram_wdata = new_q;
					state_d   = S_FINISH;
				end else if (idx_q == '0) begin
					state_d = S_INS_PLACE;
				end
			end
			S_INS_PLACE: begin
				ram_we    = 1'b1;
				ram_waddr = '0;
				ram_wdata = new_q;
				state_d   = S_FINISH;
			end
			S_REM_PRIME: begin
				state_d = S_REM_SHIFT;
			end
			S_REM_SHIFT: begin
				ram_we    = idx_q != '0;
				ram_waddr = idx_q - AW'(1);
				ram_raddr = idx_q + AW'(1);
				if (rem_last) begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (state_q == S_INS_PLACE ||
			(state_q == S_INS_SHIFT && stored_first)) begin
			count_q <= count_q + CW'(1);
		end else if (state_q == S_REM_SHIFT && rem_last) begin
			count_q <= count_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					op_q                <= op_t'(operation);
					new_q.primary_key   <= primary_key;
					new_q.secondary_key <= secondary_key;
					new_q.name_low      <= name_bytes_low & LowMask;
					new_q.name_mid      <= name_bytes_mid & MidMask;
					new_q.name_high     <= name_bytes_high & HighMask[31:0];
					status_q            <= STAT_DONE;
					if (operation == OP_INSERT) begin
						idx_q <= AW'(count_q - CW'(1));
						if (count_q == DepthCnt) begin
							status_q <= STAT_FULL;
						end
					end else begin
						idx_q <= '0;
						if (count_q == '0) begin
							status_q <= STAT_EMPTY;
						end
					end
				end
			end
			S_INS_SHIFT: begin
				idx_q <= idx_q - AW'(1);
			end
			S_REM_SHIFT: begin
				if (idx_q == '0) begin
					front_q <= rd_entry;
				end
				idx_q <= idx_q + AW'(1);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_FINISH && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_FINISH && out_free) begin
			out_status_q <= status_q;
			out_count_q  <= count_q;
			if (op_q == OP_REMOVE && status_q == STAT_DONE) begin
				out_entry_q <= front_q;
			end else begin
				out_entry_q <= '0;
			end
		end
	end

	assign out_valid         = out_valid_q;
	assign status            = out_status_q;
	assign occupancy         = out_count_q;
	assign out_primary_key   = out_entry_q.primary_key;
	assign out_secondary_key = out_entry_q.secondary_key;
	assign out_name_low      = out_entry_q.name_low;
	assign out_name_mid      = out_entry_q.name_mid;
	assign out_name_high     = out_entry_q.name_high;

endmodule

### bench/two_key_sorted_priority_queue_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_key_sorted_priority_queue_top_tb: self-checking bench for the sorted queue
// A directed opening run covers empty removes, full inserts, extreme keys and
// ties. It is followed by random fill, drain, mix and tie phases. A shadow queue
// predicts every result word, which is checked field by field as it comes out.
// ----------------------------------------------------------------------------
module two_key_sorted_priority_queue_top_tb;
	import tksq_pkg::*;

	localparam int QUEUE_DEPTH   = QueueDepthDefault;
	localparam int RANDOM_WORDS  = 1230;
	localparam int HOLD_CYCLES   = 400;
	localparam int STALL_LIMIT   = 3000;
	localparam int SETTLE_CYCLES = 40;

	typedef enum int {PH_FILL, PH_DRAIN, PH_MIX, PH_TIES} phase_t;
	typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_BURSTY} rx_mode_t;

	typedef struct {
		op_t    op;
		entry_t ent;
		bit     drain_first;
	} queue_op_t;

	typedef struct packed {
		status_t    st;
		logic [4:0] occ;
		entry_t     ent;
	} reply_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic               operation = 1'b0;
	logic signed [15:0] primary_key = '0;
	logic signed [15:0] secondary_key = '0;
	logic [63:0]        name_bytes_low = '0;
	logic [63:0]        name_bytes_mid = '0;
	logic [31:0]        name_bytes_high = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [1:0]         status;
	logic [4:0]         occupancy;
	logic signed [15:0] out_primary_key;
	logic signed [15:0] out_secondary_key;
	logic [63:0]        out_name_low;
	logic [63:0]        out_name_mid;
	logic [31:0]        out_name_high;

	queue_op_t op_backlog[$];
	reply_t    due_replies[$];
	entry_t    shadow_entries[QUEUE_DEPTH];
	int        shadow_count = 0;
	int        mismatch_count = 0;
	int        replies_seen = 0;
	bit        in_took = 1'b0;

	two_key_sorted_priority_queue_top #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.operation        (operation),
		.primary_key      (primary_key),
		.secondary_key    (secondary_key),
		.name_bytes_low   (name_bytes_low),
		.name_bytes_mid   (name_bytes_mid),
		.name_bytes_high  (name_bytes_high),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.status           (status),
		.occupancy        (occupancy),
		.out_primary_key  (out_primary_key),
		.out_secondary_key(out_secondary_key),
		.out_name_low     (out_name_low),
		.out_name_mid     (out_name_mid),
		.out_name_high    (out_name_high)
	);

	always #4 clk = ~clk;

	// Applies one word to the shadow queue and returns the reply it should give.
	function automatic reply_t apply_to_shadow(op_t op, entry_t word);
		reply_t r;
		int     pos;
		int     i;
		r = '0;
		r.st = STAT_DONE;
		if (op == OP_INSERT) begin
			if (shadow_count >= QUEUE_DEPTH) begin
				r.st = STAT_FULL;
			end else begin
				pos = 0;
				// A new entry goes ahead of stored entries with both keys equal.
				while (pos < shadow_count &&
						($signed(shadow_entries[pos].primary_key) < $signed(word.primary_key) ||
						($signed(shadow_entries[pos].primary_key) == $signed(word.primary_key) &&
						$signed(shadow_entries[pos].secondary_key) <
						$signed(word.secondary_key))))
					pos++;
				for (i = shadow_count; i > pos; i--)
					shadow_entries[i] = shadow_entries[i - 1];
				shadow_entries[pos] = word;
				shadow_entries[pos].name_low  = word.name_low & LowMask;
				shadow_entries[pos].name_mid  = word.name_mid & MidMask;
				shadow_entries[pos].name_high = word.name_high & HighMask[31:0];
				shadow_count++;
			end
		end else begin
			if (shadow_count == 0) begin
				r.st = STAT_EMPTY;
			end else begin
				r.ent = shadow_entries[0];
				for (i = 0; i + 1 < shadow_count; i++)
					shadow_entries[i] = shadow_entries[i + 1];
				shadow_count--;
			end
		end
		r.occ = shadow_count[4:0];
		return r;
	endfunction

	task automatic check_field(input string field, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", field, want, got);
			mismatch_count++;
		end
	endtask

	task automatic add_word(input op_t op, input int pkey, input int skey,
			input logic [63:0] lo, input logic [63:0] mid, input logic [31:0] hi,
			input bit drain_first);
		queue_op_t q;
		q.op                = op;
		q.ent.primary_key   = pkey[15:0];
		q.ent.secondary_key = skey[15:0];
		q.ent.name_low      = lo;
		q.ent.name_mid      = mid;
		q.ent.name_high     = hi;
		q.drain_first       = drain_first;
		op_backlog.push_back(q);
	endtask

	function automatic logic [63:0] pick_name();
		int sel;
		sel = $urandom_range(0, 15);
		if (sel == 0)
			return '1;
		else if (sel == 1)
			return '0;
		return {$urandom, $urandom};
	endfunction

	// Small keys make ties common; extremes and full-range keys fill the rest.
	function automatic int pick_key(bit tight);
		int sel;
		int k;
		sel = $urandom_range(0, 19);
		if (tight || sel < 8) begin
			k = $urandom_range(0, 6);
			return k - 3;
		end
		if (sel < 11) begin
			case ($urandom_range(0, 3))
				0: return -32768;
				1: return 32767;
				2: return -32767;
				default: return 32766;
			endcase
		end
		return $urandom_range(0, 65535);
	endfunction

	// Sender: bursts of words separated by random gaps.
	int        burst_left = 0;
	int        gap_left = 0;
	queue_op_t next_word;

	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_took)) begin
			if (gap_left != 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (op_backlog.size() == 0 ||
					(op_backlog[0].drain_first && due_replies.size() != 0)) begin
				in_valid <= 1'b0;
			end else begin
				next_word = op_backlog.pop_front();
				operation       <= next_word.op;
				primary_key     <= next_word.ent.primary_key;
				secondary_key   <= next_word.ent.secondary_key;
				name_bytes_low  <= next_word.ent.name_low;
				name_bytes_mid  <= next_word.ent.name_mid;
				name_bytes_high <= next_word.ent.name_high;
				in_valid        <= 1'b1;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 30);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				end else begin
					burst_left--;
				end
			end
		end
	end

	// Receiver: its own stall pattern, plus two long hold-offs that back the
	// block up into its input while the sender keeps offering words.
	rx_mode_t rx_mode = RX_OPEN;
	int       rx_mode_left = 0;
	int       rx_tick = 0;
	int       hold_left = 0;
	int       holds_done = 0;

	always @(negedge clk) begin
		rx_tick++;
		if (hold_left != 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if ((holds_done == 0 && replies_seen >= 300) ||
				(holds_done == 1 && replies_seen >= 850)) begin
			hold_left = HOLD_CYCLES;
			holds_done++;
			out_ready <= 1'b0;
		end else begin
			if (rx_mode_left == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 3));
				rx_mode_left = $urandom_range(10, 80);
			end else begin
				rx_mode_left--;
			end
			case (rx_mode)
				RX_OPEN:   out_ready <= 1'b1;
				RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
				RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
				default:   out_ready <= (rx_tick % 8 < 5);
			endcase
		end
	end

	// Checks the result word first, then records the prediction for a new word.
	reply_t want;

	always @(posedge clk) begin
		in_took <= arst_n && in_valid && in_ready;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				replies_seen++;
				if (due_replies.size() == 0) begin
					$error("result word with no expectation waiting");
					mismatch_count++;
				end else begin
					want = due_replies.pop_front();
					check_field("status", want.st, status);
					check_field("occupancy", want.occ, occupancy);
					check_field("out_primary_key", want.ent.primary_key, out_primary_key);
					check_field("out_secondary_key", want.ent.secondary_key,
						out_secondary_key);
					check_field("out_name_low", want.ent.name_low, out_name_low);
					check_field("out_name_mid", want.ent.name_mid, out_name_mid);
					check_field("out_name_high", want.ent.name_high, out_name_high);
				end
			end
			if (in_valid && in_ready)
				due_replies.push_back(apply_to_shadow(op_t'(operation),
					'{primary_key, secondary_key, name_bytes_low, name_bytes_mid,
					name_bytes_high}));
		end
	end

	int idle_cycles = 0;

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else if (arst_n)
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		phase_t phase;
		int     made;
		int     phase_len;
		int     insert_pct;
		int     n;
		bit     first_phase;

		// Directed opening: empty remove, a full queue with extremes and ties,
		// a rejected insert, then part of the queue drained.
		add_word(OP_REMOVE, 0, 0, '0, '0, '0, 1'b0);
		add_word(OP_INSERT, 0, 0, 64'h1111_1111_1111_1111, '0, 32'h1, 1'b0);
		add_word(OP_INSERT, 32767, 32767, '1, '1, '1, 1'b0);
		add_word(OP_INSERT, -32768, -32768, '0, '0, '0, 1'b0);
		add_word(OP_INSERT, 0, 0, 64'h2222_2222_2222_2222, '1, 32'h2, 1'b0);
		add_word(OP_INSERT, 0, -1, pick_name(), pick_name(), $urandom, 1'b0);
		add_word(OP_INSERT, 0, 1, pick_name(), pick_name(), $urandom, 1'b0);
		add_word(OP_INSERT, -32768, 32767, pick_name(), pick_name(), $urandom, 1'b0);
		add_word(OP_INSERT, 32767, -32768, pick_name(), pick_name(), $urandom, 1'b0);
		add_word(OP_INSERT, 5, 5, 64'hA, 64'hA, 32'hA, 1'b0);
		add_word(OP_INSERT, 5, 5, 64'hB, 64'hB, 32'hB, 1'b0);
		add_word(OP_INSERT, 5, 5, 64'hC, 64'hC, 32'hC, 1'b0);
		add_word(OP_INSERT, -1, 0, pick_name(), pick_name(), $urandom, 1'b0);
		add_word(OP_INSERT, 1, 0, pick_name(), pick_name(), $urandom, 1'b0);
		add_word(OP_INSERT, 100, -100, pick_name(), pick_name(), $urandom, 1'b0);
		add_word(OP_INSERT, -100, 100, pick_name(), pick_name(), $urandom, 1'b0);
		add_word(OP_INSERT, 0, 0, 64'h3333_3333_3333_3333, '0, 32'h3, 1'b0);
		add_word(OP_INSERT, -5, -5, '1, '1, '1, 1'b0);
		for (n = 0; n < 6; n++)
			add_word(OP_REMOVE, pick_key(1'b0), pick_key(1'b0), pick_name(), pick_name(),
				$urandom, 1'b0);

		// Random phases that lean toward filling, draining or ties. Some phases
		// open by waiting until the block has nothing left in flight.
		made = 0;
		first_phase = 1'b1;
		while (made < RANDOM_WORDS) begin
			phase = phase_t'($urandom_range(0, 3));
			phase_len = $urandom_range(20, 80);
			case (phase)
				PH_FILL:  insert_pct = 85;
				PH_DRAIN: insert_pct = 15;
				PH_MIX:   insert_pct = 50;
				default:  insert_pct = 60;
			endcase
			for (n = 0; n < phase_len && made < RANDOM_WORDS; n++) begin
				add_word(($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_REMOVE,
					pick_key(phase == PH_TIES), pick_key(phase == PH_TIES),
					pick_name(), pick_name(), $urandom,
					n == 0 && (first_phase || $urandom_range(0, 3) == 0));
				made++;
			end
			first_phase = 1'b0;
		end

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (op_backlog.size() != 0 || in_valid || due_replies.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);

		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

### filelist.f
sv/tksq_pkg.sv
sv/tksq_ram.sv
sv/tksq_cmp.sv
sv/two_key_sorted_priority_queue_top.sv
bench/two_key_sorted_priority_queue_top_tb.sv
